>>> hdl/sha1md_pkg.sv
`timescale 1ns / 1ps
package sha1md_pkg;

	localparam int NUM_ROUNDS  = 80;
	localparam int NUM_CHAIN   = 5;
	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS     = 56;

	localparam logic [7:0] END_MARKER = 8'h80;

	typedef logic [NUM_CHAIN-1:0][31:0] chain_t;
	typedef logic [15:0][31:0] block_t;

	localparam chain_t H_INIT = '{
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	// control from the message sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic clear_chain;
	} core_ctrl_t;

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = 32'h5a827999;
		end else if (r < 7'd40) begin
			k = 32'h6ed9eba1;
		end else if (r < 7'd60) begin
			k = 32'h8f1bbcdc;
		end else begin
			k = 32'hca62c1d6;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (x & y) ^ (~x & z);
		end else if (r < 7'd40) begin
			f = x ^ y ^ z;
		end else if (r < 7'd60) begin
			f = (x & y) ^ (x & z) ^ (y & z);
		end else begin
			f = x ^ y ^ z;
		end
		return f;
	endfunction

endpackage

>>> hdl/sha1md_core.sv
`timescale 1ns / 1ps
module sha1md_core import sha1md_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	input  block_t     blk,
	output logic       done,
	output chain_t     chain
);

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

	cstate_t     state_q;
	logic [6:0]  rnd_q;
	logic        done_q;
	chain_t      chain_q;
	chain_t      vars_q;
	block_t      sched_q;
	logic [31:0] t_sum;
	logic [31:0] w_next;

	// vars_q[0] is a, vars_q[4] is e
	assign t_sum = {vars_q[0][26:0], vars_q[0][31:27]}
		+ round_f(rnd_q, vars_q[1], vars_q[2], vars_q[3])
		+ vars_q[4] + sched_q[0] + round_k(rnd_q);

	// schedule window: sched_q[0] is the word of this round
	assign w_next = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0] ^ sched_q[0][30:0],
		sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31] ^ sched_q[0][31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			chain_q <= H_INIT;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.start) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end else if (ctrl.clear_chain) begin
						chain_q <= H_INIT;
					end
				end
				C_ROUND: begin
					if (rnd_q == 7'(NUM_ROUNDS - 1)) begin
						state_q <= C_ADD;
					end
					rnd_q <= rnd_q + 7'd1;
				end
				C_ADD: begin
					for (int i = 0; i < NUM_CHAIN; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctrl.start) begin
			vars_q  <= chain_q;
			sched_q <= blk;
		end else if (state_q == C_ROUND) begin
			vars_q[0] <= t_sum;
			vars_q[1] <= vars_q[0];
			vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
			vars_q[3] <= vars_q[2];
			vars_q[4] <= vars_q[3];
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_next;
		end
	end

	assign done  = done_q;
	assign chain = chain_q;

endmodule

>>> hdl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// sha-1 digest of a byte stream, one message byte per item. a byte that does
// not complete a 64-byte block is taken without a stall. the byte that completes a
// block holds the input stalled while the shared round unit runs its 80
// rounds, one round per cycle, and folds the result into the chaining
// words. the final item (end_of_message) adds one or two further
// compressions for the padding and length block, and then offers the five
// digest words H0..H4 on the output channel, one per accepted item. the
// input stays stalled until the last word is taken, after which a new
// message starts from the standard initial values. so a long message is
// limited by the single round unit sequenced over 80 rounds per block.
module sha1_message_digest_unit import sha1md_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {S_IDLE, S_COMP, S_PAD, S_LEN, S_OUT} state_t;

	state_t                state_q;
	state_t                ret_q;       // where to go once the compression ends
	logic [5:0]            pos_q;
	logic [63:0]           cnt_q;
	logic [2:0]            idx_q;
	logic                  start_q;
	logic                  clear_q;
	logic [BLOCK_BYTES-1:0][7:0] blk_q;
	block_t                blk_words;
	core_ctrl_t            ctrl;
	logic                  core_done;
	chain_t                chain;
	logic                  in_acc;
	logic                  out_acc;

	assign in_acc  = byte_valid && !byte_stall;
	assign out_acc = digest_valid && !digest_stall;

	// big-endian packing of the block bytes into words
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blk_words[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
		end
	end

	// message sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			start_q <= 1'b0;
			clear_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			clear_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (byte_present) begin
							pos_q <= pos_q + 6'd1;
							cnt_q <= cnt_q + 64'd8;
							if (pos_q == 6'(BLOCK_BYTES - 1)) begin
								// block full: compress before anything else
								start_q <= 1'b1;
								state_q <= S_COMP;
								ret_q   <= end_of_message ? S_PAD : S_IDLE;
							end else if (end_of_message) begin
								state_q <= S_PAD;
							end
						end else if (end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					// the length fits behind the marker unless the marker is late
					start_q <= 1'b1;
					state_q <= S_COMP;
					ret_q   <= (pos_q < 6'(LEN_POS)) ? S_OUT : S_LEN;
				end
				S_LEN: begin
					start_q <= 1'b1;
					state_q <= S_COMP;
					ret_q   <= S_OUT;
				end
				S_COMP: begin
					if (core_done) begin
						state_q <= ret_q;
						idx_q   <= '0;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (idx_q == 3'(NUM_CHAIN - 1)) begin
							state_q <= S_IDLE;
							pos_q   <= '0;
							cnt_q   <= '0;
							clear_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// block buffer: byte writes, then marker, zero fill and length
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc && byte_present) begin
			blk_q[pos_q] <= data_byte;
		end else if (state_q == S_PAD) begin
			for (int j = 0; j < BLOCK_BYTES; j++) begin
				if (6'(j) == pos_q) begin
					blk_q[j] <= END_MARKER;
				end else if (6'(j) > pos_q) begin
					if (pos_q < 6'(LEN_POS) && j >= LEN_POS) begin
						blk_q[j] <= cnt_q[8*(BLOCK_BYTES-1-j) +: 8];
					end else begin
						blk_q[j] <= 8'h00;
					end
				end
			end
		end else if (state_q == S_LEN) begin
			for (int j = 0; j < BLOCK_BYTES; j++) begin
				if (j >= LEN_POS) begin
					blk_q[j] <= cnt_q[8*(BLOCK_BYTES-1-j) +: 8];
				end else begin
					blk_q[j] <= 8'h00;
				end
			end
		end
	end

	assign ctrl.start       = start_q;
	assign ctrl.clear_chain = clear_q;

	sha1md_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.blk   (blk_words),
		.done  (core_done),
		.chain (chain)
	);

	// the chaining words hold still until the last digest word is taken
	assign byte_stall   = (state_q != S_IDLE);
	assign digest_valid = (state_q == S_OUT);
	assign digest_word  = chain[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == 3'(NUM_CHAIN - 1));

endmodule

>>> hdl/sha1md_checker.sv
`timescale 1ns / 1ps
module sha1md_checker import sha1md_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        byte_valid,
	input logic        byte_stall,
	input logic        digest_valid,
	input logic        digest_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// no byte is taken while a digest is being delivered
	a_no_input_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && byte_valid |-> byte_stall)
		else $error("byte accepted while digest pending");

	// a digest always starts with word zero
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> word_index == 3'd0)
		else $error("digest does not start at word zero");

	// words follow each other without gaps until the last one
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && !last_word |=>
			digest_valid && word_index == 3'($past(word_index) + 3'd1))
		else $error("digest word sequence broken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> last_word == (word_index == 3'(NUM_CHAIN - 1)))
		else $error("last_word flag mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |=>
			digest_valid && $stable(digest_word) && $stable(word_index))
		else $error("stalled digest item changed");

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_stall  (byte_stall),
	.digest_valid(digest_valid),
	.digest_stall(digest_stall),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
